@@ hw/rtl/arw_pkg.sv @@
// ----------------------------------------------------------------------------
// arw_pkg
// Shared widths, codes, the front-to-back command and state types of the
// ARQ receiver window.
// ----------------------------------------------------------------------------
package arw_pkg;

  localparam int SEQ_W        = 32;
  localparam int TAG_W        = 16;
  localparam int LEN_W        = 16;
  localparam int CNT_W        = 32;
  localparam int SLOT_FIELD_W = 6;
  localparam int WSIZE_W      = 6;
  localparam int CFG_INDEX_W  = 4;
  localparam int CFG_DATA_W   = 8;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_PROTOCOL_MODE = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_SIZE   = CFG_INDEX_W'(1);

  localparam logic [WSIZE_W-1:0] WINDOW_SIZE_RESET = WSIZE_W'(4);

  localparam logic MODE_GBN     = 1'b0;
  localparam logic KIND_DELIVER = 1'b0;
  localparam logic KIND_ACK     = 1'b1;

  typedef struct packed {
    logic [SEQ_W-1:0]        seq;
    logic                    ok;
    logic [TAG_W-1:0]        tag;
    logic [LEN_W-1:0]        len;
    logic [SLOT_FIELD_W-1:0] slot;
  } cmd_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIVIDE,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_FIRST,
    B_RUN,
    B_ACK
  } back_state_t;

endpackage

@@ hw/rtl/arw_front.sv @@
// ----------------------------------------------------------------------------
// arw_front
// Takes one packet, finds its window slot with a bit-serial remainder of the
// sequence number by the window length, and hands the command to the queue.
// ----------------------------------------------------------------------------
module arw_front #(
  parameter int MAX_WINDOW = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [$clog2(MAX_WINDOW + 1)-1:0]  win,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [arw_pkg::SEQ_W-1:0]          seq,
  input  logic                               checksum_ok,
  input  logic [arw_pkg::TAG_W-1:0]          payload_tag,
  input  logic [arw_pkg::LEN_W-1:0]          payload_len,
  output logic                               push,
  output arw_pkg::cmd_t                      push_data,
  input  logic                               q_full
);
  import arw_pkg::*;

  localparam int WIN_W    = $clog2(MAX_WINDOW + 1);
  localparam int CNT_BITS = $clog2(SEQ_W);

  front_state_t         state;
  front_state_t         state_next;
  logic [SEQ_W-1:0]     seq_r;
  logic [SEQ_W-1:0]     dividend;
  logic                 ok_r;
  logic [TAG_W-1:0]     tag_r;
  logic [LEN_W-1:0]     len_r;
  logic [WIN_W-1:0]     rem;
  logic [WIN_W-1:0]     rem_next;
  logic [WIN_W:0]       trial;
  logic [CNT_BITS-1:0]  cnt;
  logic                 last_bit;
  logic                 accept;

  assign accept   = in_valid && in_ready;
  assign last_bit = (cnt == CNT_BITS'(SEQ_W - 1));

  always_comb begin
    trial = {rem, dividend[SEQ_W-1]};
    if (trial >= {1'b0, win}) begin
      rem_next = WIN_W'(trial - {1'b0, win});
    end else begin
      rem_next = WIN_W'(trial);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE:   if (in_valid) state_next = F_DIVIDE;
      F_DIVIDE: if (last_bit) state_next = F_PUSH;
      F_PUSH:   if (!q_full) state_next = F_IDLE;
      default:  state_next = F_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    push     = 1'b0;
    unique case (state)
      F_IDLE:   in_ready = 1'b1;
      F_DIVIDE: ;
      F_PUSH:   push = !q_full;
      default:  ;
    endcase
  end

  assign push_data = '{seq: seq_r, ok: ok_r, tag: tag_r, len: len_r,
                       slot: SLOT_FIELD_W'(rem)};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      seq_r    <= seq;
      dividend <= seq;
      ok_r     <= checksum_ok;
      tag_r    <= payload_tag;
      len_r    <= payload_len;
      rem      <= '0;
      cnt      <= '0;
    end else if (state == F_DIVIDE) begin
      rem      <= rem_next;
      dividend <= dividend << 1;
      cnt      <= cnt + CNT_BITS'(1);
    end
  end

endmodule

@@ hw/rtl/arw_queue.sv @@
// ----------------------------------------------------------------------------
// arw_queue
// Short command queue between the classifying front and the executing back.
// ----------------------------------------------------------------------------
module arw_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  arw_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output arw_pkg::cmd_t head,
  output logic          not_empty
);
  import arw_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_B = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entry [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_B-1:0] count;

  assign full      = (count == CNT_B'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entry[rd_ptr];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (push && !pop) begin
        count <= count + CNT_B'(1);
      end else if (pop && !push) begin
        count <= count - CNT_B'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_data;
  end

endmodule

@@ hw/rtl/arw_back.sv @@
// ----------------------------------------------------------------------------
// arw_back
// Executes queued packets against the window state: delivers, buffers
// out-of-order slots, releases buffered runs and emits acknowledgements
// through a registered result stage.
// ----------------------------------------------------------------------------
module arw_back #(
  parameter int MAX_WINDOW = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               mode,
  input  logic [$clog2(MAX_WINDOW + 1)-1:0]  win,
  input  arw_pkg::cmd_t                      cmd,
  input  logic                               cmd_valid,
  output logic                               cmd_pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               kind,
  output logic [arw_pkg::SEQ_W-1:0]          seq_out,
  output logic [arw_pkg::TAG_W-1:0]          tag_out,
  output logic [arw_pkg::LEN_W-1:0]          len_out,
  output logic [arw_pkg::CNT_W-1:0]          original_count,
  output logic [arw_pkg::CNT_W-1:0]          retransmit_count,
  output logic                               last
);
  import arw_pkg::*;

  localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
  localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  back_state_t          state;
  back_state_t          state_next;

  logic [SEQ_W-1:0]     expected;
  logic [SEQ_W-1:0]     base;
  logic [CNT_W-1:0]     acc_total;
  logic [CNT_W-1:0]     rep_total;
  logic [MAX_WINDOW-1:0] slot_valid;
  logic [TAG_W-1:0]     slot_tag [MAX_WINDOW];
  logic [LEN_W-1:0]     slot_len [MAX_WINDOW];
  logic [TAG_W-1:0]     rd_tag;
  logic [LEN_W-1:0]     rd_len;

  logic [SEQ_W-1:0]     cur_seq;
  logic [TAG_W-1:0]     cur_tag;
  logic [LEN_W-1:0]     cur_len;
  logic [SEQ_W-1:0]     ack_seq;
  logic                 run_en;
  logic [SLOT_W-1:0]    idx;
  logic [SLOT_W-1:0]    idx_next;
  logic [WIN_W-1:0]     n;

  logic [SLOT_W-1:0]    slot;
  logic [SEQ_W:0]       s_ext;
  logic [SEQ_W:0]       b_ext;
  logic [SEQ_W:0]       w_ext;
  logic                 gbn;
  logic                 in_win;
  logic                 dup;
  logic                 c_gbn_hit;
  logic                 c_gbn_miss;
  logic                 c_sr_bad;
  logic                 c_sr_in;
  logic                 c_sr_base;
  logic                 c_sr_store;
  logic                 c_sr_dup;
  logic                 go_first;
  logic                 go_ack;
  logic                 run_more;
  logic                 run_emit;

  logic                 out_free;
  logic                 emit;
  logic                 e_kind;
  logic [SEQ_W-1:0]     e_seq;
  logic [TAG_W-1:0]     e_tag;
  logic [LEN_W-1:0]     e_len;
  logic                 e_last;

  function automatic logic [SLOT_W-1:0] slot_wrap(input logic [SLOT_W-1:0] i,
                                                  input logic [WIN_W-1:0] w);
    logic [WIN_W-1:0] inc;
    inc = WIN_W'(i) + WIN_W'(1);
    slot_wrap = (inc == w) ? '0 : SLOT_W'(inc);
  endfunction

  assign slot  = cmd.slot[SLOT_W-1:0];
  assign s_ext = {1'b0, cmd.seq};
  assign b_ext = {1'b0, base};
  assign w_ext = (SEQ_W + 1)'(win);
  assign gbn   = (mode == MODE_GBN);

  assign in_win = (cmd.seq >= base) && (s_ext < b_ext + w_ext);
  assign dup    = (cmd.seq < base) && (s_ext + w_ext >= b_ext);

  assign c_gbn_hit  = gbn && (cmd.seq == expected) && cmd.ok;
  assign c_gbn_miss = gbn && (cmd.seq != expected);
  assign c_sr_bad   = !gbn && !cmd.ok;
  assign c_sr_in    = !gbn && cmd.ok && in_win;
  assign c_sr_base  = c_sr_in && (cmd.seq == base);
  assign c_sr_store = c_sr_in && (cmd.seq != base);
  assign c_sr_dup   = !gbn && cmd.ok && !in_win && dup;

  assign go_first = c_gbn_hit || c_sr_base;
  assign go_ack   = c_sr_store || c_sr_dup || (c_gbn_miss && (expected != '0));

  assign run_more = (({1'b0, n} + (WIN_W + 1)'(1)) < {1'b0, win}) && slot_valid[idx];
  assign out_free = !out_valid || out_ready;
  assign run_emit = (state == B_RUN) && emit;

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (cmd_valid) begin
          if (go_first) begin
            state_next = B_FIRST;
          end else if (go_ack) begin
            state_next = B_ACK;
          end
        end
      end
      B_FIRST: if (out_free) state_next = run_en ? B_RUN : B_ACK;
      B_RUN:   if (!run_more) state_next = B_ACK;
      B_ACK:   if (out_free) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop = 1'b0;
    emit    = 1'b0;
    e_kind  = KIND_DELIVER;
    e_seq   = cur_seq;
    e_tag   = cur_tag;
    e_len   = cur_len;
    e_last  = 1'b0;
    unique case (state)
      B_IDLE:  cmd_pop = cmd_valid;
      B_FIRST: emit = out_free;
      B_RUN: begin
        emit  = out_free && run_more;
        e_seq = base;
        e_tag = rd_tag;
        e_len = rd_len;
      end
      B_ACK: begin
        emit   = out_free;
        e_kind = KIND_ACK;
        e_seq  = ack_seq;
        e_tag  = '0;
        e_len  = '0;
        e_last = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    idx_next = idx;
    if (cmd_pop && c_sr_base) begin
      idx_next = slot_wrap(slot, win);
    end else if (run_emit) begin
      idx_next = slot_wrap(idx, win);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected   <= '0;
      base       <= '0;
      acc_total  <= '0;
      rep_total  <= '0;
      slot_valid <= '0;
    end else begin
      if (cmd_pop) begin
        if (c_gbn_hit) begin
          expected  <= expected + SEQ_W'(1);
          acc_total <= acc_total + CNT_W'(1);
        end
        if (c_gbn_miss || c_sr_bad) rep_total <= rep_total + CNT_W'(1);
        if (c_sr_in) acc_total <= acc_total + CNT_W'(1);
        if (c_sr_base) begin
          slot_valid[slot] <= 1'b0;
          base             <= base + SEQ_W'(1);
        end
        if (c_sr_store) slot_valid[slot] <= 1'b1;
      end
      if (run_emit) begin
        slot_valid[idx] <= 1'b0;
        base            <= base + SEQ_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur_seq <= cmd.seq;
      cur_tag <= cmd.tag;
      cur_len <= cmd.len;
      ack_seq <= c_gbn_miss ? expected - SEQ_W'(1) : cmd.seq;
      run_en  <= c_sr_base;
      n       <= '0;
    end else if (run_emit) begin
      n <= n + WIN_W'(1);
    end
    idx <= idx_next;
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && c_sr_store) begin
      slot_tag[slot] <= cmd.tag;
      slot_len[slot] <= cmd.len;
    end
    rd_tag <= slot_tag[idx_next];
    rd_len <= slot_len[idx_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind             <= e_kind;
      seq_out          <= e_seq;
      tag_out          <= e_tag;
      len_out          <= e_len;
      original_count   <= acc_total;
      retransmit_count <= rep_total;
      last             <= e_last;
    end
  end

endmodule

@@ hw/rtl/arq_receiver_window_top.sv @@
// ----------------------------------------------------------------------------
// arq_receiver_window_top
// Go-back-N / selective-repeat ARQ receiver with configuration registers.
// Packets are taken one at a time: the front accepts one, runs the bit-serial
//   slot remainder in 32 divide steps, then pushes the command to the queue.
// Commands pass the queue and the back's states to a registered result stage;
//   a release run gives one delivery per cycle unless stalled, then the ack.
// Reset clears window, counters and slot valid bits at once; slot payload
//   storage is not cleared.
// ----------------------------------------------------------------------------
module arq_receiver_window_top #(
  parameter int MAX_WINDOW = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [arw_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [arw_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [arw_pkg::SEQ_W-1:0]        seq,
  input  logic                             checksum_ok,
  input  logic [arw_pkg::TAG_W-1:0]        payload_tag,
  input  logic [arw_pkg::LEN_W-1:0]        payload_len,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             kind,
  output logic [arw_pkg::SEQ_W-1:0]        seq_out,
  output logic [arw_pkg::TAG_W-1:0]        tag_out,
  output logic [arw_pkg::LEN_W-1:0]        len_out,
  output logic [arw_pkg::CNT_W-1:0]        original_count,
  output logic [arw_pkg::CNT_W-1:0]        retransmit_count,
  output logic                             last
);
  import arw_pkg::*;

  localparam int WIN_W = $clog2(MAX_WINDOW + 1);

  logic               protocol_mode;
  logic [WSIZE_W-1:0] win_len;
  logic [WIN_W-1:0]   win;
  logic               push;
  cmd_t               push_data;
  logic               q_full;
  logic               pop;
  cmd_t               head;
  logic               not_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      protocol_mode <= MODE_GBN;
      win_len       <= WINDOW_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PROTOCOL_MODE: protocol_mode <= cfg_data[0];
        REG_WINDOW_SIZE:   win_len       <= cfg_data[WSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp window length to 1..MAX_WINDOW
  always_comb begin
    if (win_len == '0) begin
      win = WIN_W'(1);
    end else if (int'(win_len) > MAX_WINDOW) begin
      win = WIN_W'(MAX_WINDOW);
    end else begin
      win = WIN_W'(win_len);
    end
  end

  arw_front #(.MAX_WINDOW(MAX_WINDOW)) u_front (
    .clk         (clk),
    .rst         (rst),
    .win         (win),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .seq         (seq),
    .checksum_ok (checksum_ok),
    .payload_tag (payload_tag),
    .payload_len (payload_len),
    .push        (push),
    .push_data   (push_data),
    .q_full      (q_full)
  );

  arw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty)
  );

  arw_back #(.MAX_WINDOW(MAX_WINDOW)) u_back (
    .clk              (clk),
    .rst              (rst),
    .mode             (protocol_mode),
    .win              (win),
    .cmd              (head),
    .cmd_valid        (not_empty),
    .cmd_pop          (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .kind             (kind),
    .seq_out          (seq_out),
    .tag_out          (tag_out),
    .len_out          (len_out),
    .original_count   (original_count),
    .retransmit_count (retransmit_count),
    .last             (last)
  );

endmodule

@@ hw/rtl/arw_checker.sv @@
// ----------------------------------------------------------------------------
// arw_checker
// Port-level checks of the ARQ receiver window, bound to the top level.
// ----------------------------------------------------------------------------
module arw_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       kind,
  input logic [arw_pkg::SEQ_W-1:0]  seq_out,
  input logic [arw_pkg::TAG_W-1:0]  tag_out,
  input logic [arw_pkg::LEN_W-1:0]  len_out,
  input logic                       last
);
  import arw_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(seq_out) && $stable(kind)
      && $stable(last))
    else $error("result changed while stalled");

  a_deliver_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_DELIVER) |-> !last)
    else $error("delivery flagged as final result");

  a_ack_no_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_ACK) |-> (tag_out == '0) && (len_out == '0))
    else $error("ack carries payload");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken during slot computation");

endmodule

bind arq_receiver_window_top arw_checker u_arw_checker (.*);

@@ tb/sv/arw_result_checker.sv @@
// ----------------------------------------------------------------------------
// arw_result_checker
// Watches the configuration, packet and result channels of the ARQ receiver
// window, keeps its own go-back-N / selective-repeat receiver state, predicts
// the deliveries and acks of every accepted packet and compares each result
// transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module arw_result_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [arw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [arw_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [arw_pkg::SEQ_W-1:0]       seq,
  input  logic                            checksum_ok,
  input  logic [arw_pkg::TAG_W-1:0]       payload_tag,
  input  logic [arw_pkg::LEN_W-1:0]       payload_len,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic                            kind,
  input  logic [arw_pkg::SEQ_W-1:0]       seq_out,
  input  logic [arw_pkg::TAG_W-1:0]       tag_out,
  input  logic [arw_pkg::LEN_W-1:0]       len_out,
  input  logic [arw_pkg::CNT_W-1:0]       original_count,
  input  logic [arw_pkg::CNT_W-1:0]       retransmit_count,
  input  logic                            last,
  output int                              errors,
  output int                              pending,
  output int                              compared,
  output logic [arw_pkg::SEQ_W-1:0]       next_seq,
  output logic [arw_pkg::SEQ_W-1:0]       window_base
);
  import arw_pkg::*;

  localparam int WINDOW_MAX = 32;

  typedef struct packed {
    logic             kind;
    logic [SEQ_W-1:0] seq;
    logic [TAG_W-1:0] tag;
    logic [LEN_W-1:0] len;
    logic [CNT_W-1:0] orig;
    logic [CNT_W-1:0] retx;
    logic             last;
  } arq_result_t;

  arq_result_t        due_results[$];
  arq_result_t        want;
  logic               mode;
  logic [WSIZE_W-1:0] wsize;
  logic               slot_full [WINDOW_MAX];
  logic [TAG_W-1:0]   slot_tag  [WINDOW_MAX];
  logic [LEN_W-1:0]   slot_len  [WINDOW_MAX];
  logic [CNT_W-1:0]   accepted_total;
  logic [CNT_W-1:0]   repeat_total;

  function automatic arq_result_t result_of(input logic k, input logic [SEQ_W-1:0] s,
                                            input logic [TAG_W-1:0] t,
                                            input logic [LEN_W-1:0] l);
    arq_result_t r;
    r      = '0;
    r.kind = k;
    r.seq  = s;
    r.tag  = t;
    r.len  = l;
    return r;
  endfunction

  function automatic void absorb_packet(input logic [SEQ_W-1:0] s, input logic ok,
                                        input logic [TAG_W-1:0] t,
                                        input logic [LEN_W-1:0] l);
    arq_result_t fresh[$];
    arq_result_t r;
    int unsigned w;
    int unsigned idx;
    int unsigned n;
    longint      wl;
    longint      sv;
    longint      bv;
    w  = (wsize == 0) ? 1 : ((wsize > WINDOW_MAX) ? WINDOW_MAX : wsize);
    wl = w;
    sv = {32'b0, s};
    bv = {32'b0, window_base};
    if (mode == MODE_GBN) begin
      if (s == next_seq) begin
        if (ok) begin
          fresh.push_back(result_of(KIND_DELIVER, s, t, l));
          fresh.push_back(result_of(KIND_ACK, s, '0, '0));
          next_seq++;
          accepted_total++;
        end
      end else begin
        repeat_total++;
        if (next_seq != 0) fresh.push_back(result_of(KIND_ACK, next_seq - 1, '0, '0));
      end
    end else if (!ok) begin
      repeat_total++;
    end else if (sv >= bv && sv < bv + wl) begin
      accepted_total++;
      if (s != window_base) begin
        idx           = s % w;
        slot_full[idx] = 1'b1;
        slot_tag[idx]  = t;
        slot_len[idx]  = l;
      end else begin
        fresh.push_back(result_of(KIND_DELIVER, s, t, l));
        slot_full[window_base % w] = 1'b0;
        window_base++;
        idx = window_base % w;
        n   = 0;
        while (n + 1 < w && slot_full[idx]) begin
          fresh.push_back(result_of(KIND_DELIVER, window_base, slot_tag[idx], slot_len[idx]));
          slot_full[idx] = 1'b0;
          idx = (idx + 1) % w;
          window_base++;
          n++;
        end
      end
      fresh.push_back(result_of(KIND_ACK, s, '0, '0));
    end else if (sv >= bv - wl && sv <= bv - 1) begin
      fresh.push_back(result_of(KIND_ACK, s, '0, '0));
    end
    foreach (fresh[i]) begin
      r      = fresh[i];
      r.orig = accepted_total;
      r.retx = repeat_total;
      r.last = (i == fresh.size() - 1);
      due_results.push_back(r);
    end
  endfunction

  function automatic void check_field(input string name, input logic [63:0] exp_val,
                                      input logic [63:0] got_val);
    if (exp_val !== got_val) begin
      errors++;
      $error("%s: expected %0h, got %0h", name, exp_val, got_val);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      mode           = MODE_GBN;
      wsize          = WINDOW_SIZE_RESET;
      next_seq       = '0;
      window_base    = '0;
      accepted_total = '0;
      repeat_total   = '0;
      foreach (slot_full[i]) slot_full[i] = 1'b0;
      due_results.delete();
      errors   = 0;
      compared = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_PROTOCOL_MODE) mode = cfg_data[0];
        else if (cfg_index == REG_WINDOW_SIZE) wsize = cfg_data[WSIZE_W-1:0];
      end
      if (in_valid && in_ready) absorb_packet(seq, checksum_ok, payload_tag, payload_len);
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          errors++;
          $error("result transfer with nothing expected: kind %0d seq_out %0h", kind, seq_out);
        end else begin
          want = due_results.pop_front();
          compared++;
          check_field("kind", want.kind, kind);
          check_field("seq_out", want.seq, seq_out);
          check_field("tag_out", want.tag, tag_out);
          check_field("len_out", want.len, len_out);
          check_field("original_count", want.orig, original_count);
          check_field("retransmit_count", want.retx, retransmit_count);
          check_field("last", want.last, last);
        end
      end
    end
    pending = due_results.size();
  end

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the ARQ receiver window: a directed go-back-N and
// selective-repeat opening, then random phases over several register settings
// and idle patterns, mostly in-window packet bursts, with two long output
// hold-offs. Prediction and comparison live in arw_result_checker.
// ----------------------------------------------------------------------------
module tb;
  import arw_pkg::*;

  localparam int HALF_PERIOD     = 5;
  localparam int RESET_CYCLES    = 9;
  localparam int SETTLE_CYCLES   = 120;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int WINDOW_MAX      = 32;
  localparam int HEAVY_IDLE_PCT  = 69;
  localparam int MIXED_IDLE_PCT  = 28;

  localparam logic                   MODE_SR      = 1'b1;
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = '1;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic             ok;
  } planned_pkt_t;

  logic                   clk         = 1'b0;
  logic                   rst         = 1'b1;
  logic                   cfg_valid   = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data    = '0;
  logic                   in_valid    = 1'b0;
  logic                   in_ready;
  logic [SEQ_W-1:0]       seq         = '0;
  logic                   checksum_ok = 1'b0;
  logic [TAG_W-1:0]       payload_tag = '0;
  logic [LEN_W-1:0]       payload_len = '0;
  logic                   out_valid;
  logic                   out_ready   = 1'b0;
  logic                   kind;
  logic [SEQ_W-1:0]       seq_out;
  logic [TAG_W-1:0]       tag_out;
  logic [LEN_W-1:0]       len_out;
  logic [CNT_W-1:0]       original_count;
  logic [CNT_W-1:0]       retransmit_count;
  logic                   last;

  int               errors;
  int               pending;
  int               compared;
  logic [SEQ_W-1:0] next_seq;
  logic [SEQ_W-1:0] window_base;

  int           send_idle_pct  = 0;
  int           recv_stall_pct = 0;
  bit           long_hold      = 1'b0;
  logic         cur_mode       = MODE_GBN;
  int unsigned  cur_window     = 4;
  int           items_sent     = 0;
  int           settings_run   = 0;
  int           quiet_cycles   = 0;
  planned_pkt_t sr_plan[$];

  arq_receiver_window_top u_dut (.*);

  arw_result_checker u_checker (.*);

  always #HALF_PERIOD clk = ~clk;

  initial begin
    forever begin
      @(negedge clk);
      if (long_hold) begin
        long_hold = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  function automatic logic [15:0] random_handle();
    int pick;
    pick = $urandom_range(15);
    if (pick == 0) return 16'h0000;
    if (pick == 1) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  task automatic send_packet(input logic [SEQ_W-1:0] s, input logic ok,
                             input logic [TAG_W-1:0] t, input logic [LEN_W-1:0] l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    seq         <= s;
    checksum_ok <= ok;
    payload_tag <= t;
    payload_len <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle();
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic plan_sr_burst();
    planned_pkt_t p;
    planned_pkt_t tmp;
    logic [SEQ_W-1:0] base;
    int unsigned w;
    int pick;
    int k;
    int j;
    bit full;
    w    = cur_window;
    base = window_base;
    pick = $urandom_range(99);
    if (pick < 60) begin
      full = ($urandom_range(3) == 0);
      k    = full ? w : $urandom_range(1, w);
      for (int i = full ? 1 : 0; i < k; i++) begin
        p.seq = base + i;
        p.ok  = full ? 1'b1 : ($urandom_range(14) != 0);
        sr_plan.push_back(p);
      end
      for (int i = sr_plan.size() - 1; i > 0; i--) begin
        j          = $urandom_range(0, i);
        tmp        = sr_plan[i];
        sr_plan[i] = sr_plan[j];
        sr_plan[j] = tmp;
      end
      if (full) begin
        p.seq = base;
        p.ok  = 1'b1;
        sr_plan.push_back(p);
      end
    end else if (pick < 75) begin
      k = $urandom_range(1, 3);
      repeat (k) begin
        p.seq = base - $urandom_range(1, w);
        p.ok  = 1'b1;
        sr_plan.push_back(p);
      end
    end else if (pick < 87) begin
      p.seq = base + $urandom_range(0, w - 1);
      p.ok  = 1'b0;
      sr_plan.push_back(p);
    end else begin
      p.seq = $urandom_range(1) ? $urandom : base + w + $urandom_range(0, 40);
      p.ok  = 1'b1;
      sr_plan.push_back(p);
    end
  endtask

  task automatic send_next();
    planned_pkt_t p;
    logic [SEQ_W-1:0] s;
    logic ok;
    int pick;
    if (cur_mode == MODE_GBN) begin
      pick = $urandom_range(99);
      ok   = ($urandom_range(9) != 0);
      if (pick < 65) s = next_seq;
      else if (pick < 85) s = next_seq - $urandom_range(1, 4);
      else s = $urandom;
    end else begin
      if (sr_plan.size() == 0) plan_sr_burst();
      p  = sr_plan.pop_front();
      s  = p.seq;
      ok = p.ok;
    end
    send_packet(s, ok, random_handle(), random_handle());
  endtask

  task automatic run_phase(input logic m, input int wsize, input idle_mode_t im,
                           input int count, input bit squeeze);
    settle();
    write_reg(REG_PROTOCOL_MODE, {7'($urandom_range(127)), m});
    write_reg(REG_WINDOW_SIZE, {2'($urandom_range(3)), 6'(wsize)});
    write_reg(REG_UNMAPPED, 8'($urandom));
    cfg_valid <= 1'b0;
    cur_mode   = m;
    cur_window = (wsize == 0) ? 1 : ((wsize > WINDOW_MAX) ? WINDOW_MAX : wsize);
    settings_run++;
    case (im)
      IDLE_NONE: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct  = HEAVY_IDLE_PCT;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct  = 0;
        recv_stall_pct = HEAVY_IDLE_PCT;
      end
      default: begin
        send_idle_pct  = MIXED_IDLE_PCT;
        recv_stall_pct = MIXED_IDLE_PCT;
      end
    endcase
    if (squeeze) long_hold = 1'b1;
    sr_plan.delete();
    repeat (count) send_next();
    in_valid <= 1'b0;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    send_packet(32'd7, 1'b1, 16'h1111, 16'h0010);
    send_packet(32'd0, 1'b0, 16'h2222, 16'h0020);
    send_packet(32'd0, 1'b1, 16'hFFFF, 16'hFFFF);
    send_packet(32'd1, 1'b1, 16'h0000, 16'h0000);
    send_packet(32'd0, 1'b1, 16'h3333, 16'h0030);
    send_packet(32'hFFFF_FFFF, 1'b0, 16'h4444, 16'h0040);
    send_packet(32'd2, 1'b1, 16'hA5A5, 16'h5A5A);
    in_valid <= 1'b0;

    settle();
    write_reg(REG_PROTOCOL_MODE, 8'hFF);
    write_reg(REG_WINDOW_SIZE, 8'hC4);
    cfg_valid <= 1'b0;
    cur_mode   = MODE_SR;
    cur_window = 4;
    settings_run++;

    send_packet(32'hFFFF_FFFF, 1'b1, 16'h5555, 16'h0050);
    send_packet(32'd0, 1'b0, 16'h6666, 16'h0060);
    send_packet(32'd2, 1'b1, 16'h7777, 16'h0070);
    send_packet(32'd3, 1'b1, 16'h8888, 16'h0080);
    send_packet(32'd2, 1'b1, 16'h9999, 16'h0090);
    send_packet(32'd1, 1'b1, 16'hAAAA, 16'h00A0);
    send_packet(32'd0, 1'b1, 16'hBBBB, 16'h00B0);
    send_packet(32'd4, 1'b1, 16'hCCCC, 16'h00C0);
    send_packet(32'd2, 1'b1, 16'hDDDD, 16'h00D0);
    send_packet(32'd1, 1'b1, 16'hEEEE, 16'h00E0);
    send_packet(32'd0, 1'b1, 16'h0F0F, 16'h00F0);
    send_packet(32'd9, 1'b1, 16'h1234, 16'h0100);
    send_packet(32'd8, 1'b1, 16'h2345, 16'h0110);
    send_packet(32'd5, 1'b1, 16'h3456, 16'h0120);
    send_packet(32'd6, 1'b1, 16'h4567, 16'h0130);
    send_packet(32'd7, 1'b1, 16'h5678, 16'h0140);
    in_valid <= 1'b0;

    run_phase(MODE_SR, 32, IDLE_NONE, 30, 1'b1);
    run_phase(MODE_GBN, 0, IDLE_SENDER, 25, 1'b0);
    run_phase(MODE_SR, 0, IDLE_RECEIVER, 20, 1'b0);
    run_phase(MODE_SR, 63, IDLE_BOTH, 30, 1'b0);
    run_phase(MODE_SR, 7, IDLE_NONE, 25, 1'b0);
    run_phase(MODE_GBN, 32, IDLE_BOTH, 25, 1'b0);
    run_phase(MODE_SR, 1, IDLE_SENDER, 15, 1'b0);
    run_phase(MODE_SR, 16, IDLE_RECEIVER, 30, 1'b1);

    settle();
    $display("tb: %0d packets under %0d register settings, %0d results compared",
             items_sent, settings_run, compared);
    $display("tb: both modes, windows 0 to 63, all idle patterns, output hold-off");
    if (errors == 0 && pending == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
